// ===== rtl/core/mwvu_pkg.sv =====
// Shared types and constants for the mixture weighted variance update core.
// No dependencies; every other file of the block but mwvu_ram imports this package.
package mwvu_pkg;

  // default sizes, used as defaults by the top level parameters
  localparam int DEF_MAX_SAMPLES    = 1024;
  localparam int DEF_MAX_DIMS       = 16;
  localparam int DEF_MAX_COMPONENTS = 8;

  // port field widths
  localparam int OPW   = 3;
  localparam int ROWW  = 10;
  localparam int COMPW = 3;
  localparam int DIMW  = 4;
  localparam int VALW  = 64;
  localparam int VARW  = 64;
  localparam int SRCW  = 2;
  localparam int CFGW  = 32;
  localparam int CFGIW = 2;
  localparam int CNTW  = 11;

  // internal arithmetic
  localparam int XW        = 32;   // Q16.16 sample / mean
  localparam int PW        = 17;   // Q1.16 posterior
  localparam int WIDEW     = 128;  // exact sums
  localparam int MULBW     = 64;
  localparam int MUL_STEPS = 64;
  localparam int DIV_STEPS = 128;

  localparam logic [OPW-1:0] OP_LOAD_SAMPLE    = 3'd0;
  localparam logic [OPW-1:0] OP_LOAD_POSTERIOR = 3'd1;
  localparam logic [OPW-1:0] OP_LOAD_MEAN      = 3'd2;
  localparam logic [OPW-1:0] OP_LOAD_FLOOR     = 3'd3;
  localparam logic [OPW-1:0] OP_COMPUTE        = 3'd4;

  localparam logic [SRCW-1:0] SRC_WEIGHTED = 2'd0;
  localparam logic [SRCW-1:0] SRC_FLOOR    = 2'd1;
  localparam logic [SRCW-1:0] SRC_GLOBAL   = 2'd2;
  localparam logic [SRCW-1:0] SRC_FALLBACK = 2'd3;

  localparam logic [CFGIW-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFGIW-1:0] REG_TINY_LIMIT   = 2'd1;
  localparam logic [CFGIW-1:0] REG_FALLBACK     = 2'd2;

  localparam logic [CNTW-1:0] RST_SAMPLE_COUNT = 11'd1024;
  localparam logic [CFGW-1:0] RST_TINY_LIMIT   = 32'd1;
  localparam logic [CFGW-1:0] RST_FALLBACK     = 32'd4295;

  localparam logic MUL_SEL_SXX_N  = 1'b0;
  localparam logic MUL_SEL_SX_SQ  = 1'b1;
  localparam logic DIV_SEL_GLOBAL = 1'b0;
  localparam logic DIV_SEL_WEIGHT = 1'b1;

  typedef struct packed {
    logic take;
    logic start_loop;
    logic mul_start;
    logic mul_sel;
    logic num_load;
    logic num_sub;
    logic div_start;
    logic div_sel;
    logic g_set;
    logic v_set;
    logic finish;
  } mwvu_cmd_t;

  typedef struct packed {
    logic is_compute;
    logic loop_done;
    logic mul_busy;
    logic div_busy;
    logic n_lt2;
    logic psum_zero;
    logic out_free;
  } mwvu_sts_t;

endpackage

// ===== rtl/core/mwvu_if.sv =====
// Request and result channel interfaces (valid/ready plus payload).
// Depends on mwvu_pkg.
interface mwvu_item_if import mwvu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OPW-1:0]  operation;
  logic [ROWW-1:0] sample_index;
  logic [COMPW-1:0] component;
  logic [DIMW-1:0] dimension;
  logic [VALW-1:0] value;

  modport source(output valid, operation, sample_index, component, dimension, value,
                 input ready);
  modport sink(input valid, operation, sample_index, component, dimension, value,
               output ready);
endinterface

interface mwvu_result_if import mwvu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COMPW-1:0] component_out;
  logic [DIMW-1:0]  dimension_out;
  logic [VARW-1:0]  variance;
  logic [SRCW-1:0]  source_out;

  modport source(output valid, component_out, dimension_out, variance, source_out,
                 input ready);
  modport sink(input valid, component_out, dimension_out, variance, source_out,
               output ready);
endinterface

// ===== rtl/core/mwvu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwvu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mwvu_datapath.sv =====
// Datapath: stores, config registers, sample pipeline, shift-add multiplier,
// restoring divider and result register. Depends on mwvu_pkg and mwvu_ram.
module mwvu_datapath import mwvu_pkg::*; #(
  parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
  parameter int MAX_DIMS       = DEF_MAX_DIMS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [OPW-1:0]    operation,
  input  logic [ROWW-1:0]   sample_index,
  input  logic [COMPW-1:0]  component,
  input  logic [DIMW-1:0]   dimension,
  input  logic [VALW-1:0]   value,
  input  logic              cfg_we,
  input  logic [CFGIW-1:0]  cfg_index,
  input  logic [CFGW-1:0]   cfg_data,
  input  mwvu_cmd_t         cmd,
  output mwvu_sts_t         sts,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [COMPW-1:0]  component_out,
  output logic [DIMW-1:0]   dimension_out,
  output logic [VARW-1:0]   variance,
  output logic [SRCW-1:0]   source
);

  localparam int SDEPTH = MAX_SAMPLES * MAX_DIMS;
  localparam int PDEPTH = MAX_SAMPLES * MAX_COMPONENTS;
  localparam int CDEPTH = MAX_COMPONENTS * MAX_DIMS;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int PAW    = $clog2(PDEPTH);
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int NW     = $clog2(MAX_SAMPLES + 1);
  localparam int PSW    = PW + $clog2(MAX_SAMPLES);
  localparam int SXW    = XW + 1 + $clog2(MAX_SAMPLES);
  localparam int MCW    = $clog2(MUL_STEPS);
  localparam int DCW    = $clog2(DIV_STEPS);

  // configuration
  logic [CNTW-1:0] sample_count;
  logic [CFGW-1:0] tiny_limit;
  logic [CFGW-1:0] fallback_variance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count      <= RST_SAMPLE_COUNT;
      tiny_limit        <= RST_TINY_LIMIT;
      fallback_variance <= RST_FALLBACK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_COUNT: sample_count      <= cfg_data[CNTW-1:0];
        REG_TINY_LIMIT:   tiny_limit        <= cfg_data;
        REG_FALLBACK:     fallback_variance <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [VARW-1:0] tiny64, fall64;
  assign tiny64 = VARW'(tiny_limit);
  assign fall64 = VARW'(fallback_variance);

  // request decode
  logic in_range, is_row_op;
  assign is_row_op = (operation == OP_LOAD_SAMPLE) || (operation == OP_LOAD_POSTERIOR);
  assign in_range  = (32'(component) < MAX_COMPONENTS) && (32'(dimension) < MAX_DIMS) &&
                     (!is_row_op || (32'(sample_index) < MAX_SAMPLES));

  logic s_we, p_we, m_we, fl_we;
  assign s_we  = cmd.take && in_range && (operation == OP_LOAD_SAMPLE);
  assign p_we  = cmd.take && in_range && (operation == OP_LOAD_POSTERIOR);
  assign m_we  = cmd.take && in_range && (operation == OP_LOAD_MEAN);
  assign fl_we = cmd.take && in_range && (operation == OP_LOAD_FLOOR);

  logic [SAW-1:0] s_waddr;
  logic [PAW-1:0] p_waddr;
  logic [CAW-1:0] c_waddr;
  assign s_waddr = SAW'(32'(sample_index) * MAX_DIMS + 32'(dimension));
  assign p_waddr = PAW'(32'(sample_index) * MAX_COMPONENTS + 32'(component));
  assign c_waddr = CAW'(32'(component) * MAX_DIMS + 32'(dimension));

  // compute context
  logic [COMPW-1:0] ctx_comp;
  logic [DIMW-1:0]  ctx_dim;
  logic [CAW-1:0]   ctx_addr;
  logic [NW-1:0]    n_reg;

  always_ff @(posedge clk) begin
    if (cmd.take && in_range && (operation == OP_COMPUTE)) begin
      ctx_comp <= component;
      ctx_dim  <= dimension;
      ctx_addr <= c_waddr;
      n_reg    <= (32'(sample_count) > MAX_SAMPLES) ? NW'(MAX_SAMPLES) : NW'(sample_count);
    end
  end

  // sample walk
  logic           loop_active;
  logic [NW-1:0]  j;
  logic [SAW-1:0] sa;
  logic [PAW-1:0] pa;
  logic           v0, v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_active <= 1'b0;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (cmd.start_loop) begin
        loop_active <= (n_reg != '0);
      end else if (loop_active) begin
        loop_active <= (j + NW'(1) != n_reg);
      end
      v0 <= loop_active;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_loop) begin
      j  <= '0;
      sa <= SAW'(ctx_dim);
      pa <= PAW'(ctx_comp);
    end else if (loop_active) begin
      j  <= j + NW'(1);
      sa <= sa + SAW'(MAX_DIMS);
      pa <= pa + PAW'(MAX_COMPONENTS);
    end
  end

  // stores
  logic [XW-1:0]   s_rdata, m_rdata;
  logic [PW-1:0]   p_rdata;
  logic [VARW-1:0] f_rdata, f_wdata, v_final;
  logic [SRCW-1:0] src_final;
  logic            f_we, fin_upd;

  assign f_we    = fl_we || (cmd.finish && fin_upd);
  assign f_wdata = cmd.finish ? v_final : value;

  mwvu_ram #(.WIDTH(XW), .DEPTH(SDEPTH)) u_sample_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(value[XW-1:0]),
    .raddr(sa), .rdata(s_rdata)
  );

  mwvu_ram #(.WIDTH(PW), .DEPTH(PDEPTH)) u_post_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(value[PW-1:0]),
    .raddr(pa), .rdata(p_rdata)
  );

  mwvu_ram #(.WIDTH(XW), .DEPTH(CDEPTH)) u_mean_ram (
    .clk(clk), .we(m_we), .waddr(c_waddr), .wdata(value[XW-1:0]),
    .raddr(ctx_addr), .rdata(m_rdata)
  );

  mwvu_ram #(.WIDTH(VARW), .DEPTH(CDEPTH)) u_floor_ram (
    .clk(clk), .we(f_we), .waddr(cmd.finish ? ctx_addr : c_waddr), .wdata(f_wdata),
    .raddr(ctx_addr), .rdata(f_rdata)
  );

  // pipeline stage 1: deviations
  logic signed [XW:0] diff;
  logic [XW:0]        dm;
  logic [XW-1:0]      xm;
  assign diff = $signed({s_rdata[XW-1], s_rdata}) - $signed({m_rdata[XW-1], m_rdata});
  assign dm   = diff[XW] ? (~diff + 1'b1) : diff;
  assign xm   = s_rdata[XW-1] ? (~s_rdata + 1'b1) : s_rdata;

  logic [XW:0]          dm1;
  logic [XW-1:0]        xm1;
  logic signed [XW-1:0] x1;
  logic [PW-1:0]        p1, p2;
  logic [2*XW+1:0]      sq2;
  logic [2*XW-1:0]      xsq2, xsq3;
  logic [PW+2*XW:0]     prod3;

  always_ff @(posedge clk) begin
    dm1   <= dm;
    xm1   <= xm;
    x1    <= $signed(s_rdata);
    p1    <= p_rdata;
    sq2   <= dm1 * dm1;
    xsq2  <= xm1 * xm1;
    p2    <= p1;
    prod3 <= (PW+2*XW+1)'(p2) * (PW+2*XW+1)'(sq2);
    xsq3  <= xsq2;
  end

  // accumulators
  logic [WIDEW-1:0]      acc, sxx;
  logic [PSW-1:0]        psum;
  logic signed [SXW-1:0] sx;

  always_ff @(posedge clk) begin
    if (cmd.start_loop) begin
      acc  <= '0;
      sxx  <= '0;
      psum <= '0;
      sx   <= '0;
    end else begin
      if (v1) begin
        psum <= psum + PSW'(p1);
        sx   <= sx + SXW'(x1);
      end
      if (v3) begin
        acc <= acc + WIDEW'(prod3);
        sxx <= sxx + WIDEW'(xsq3);
      end
    end
  end

  logic [SXW-1:0] sx_mag;
  assign sx_mag = sx[SXW-1] ? (~sx + 1'b1) : sx;

  // shift-add multiplier, one multiplier bit per cycle
  logic [WIDEW-1:0] mul_a, mul_p, num;
  logic [MULBW-1:0] mul_b;
  logic [MCW-1:0]   mul_cnt;
  logic             mul_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy <= 1'b1;
    end else if (mul_busy && (mul_cnt == MCW'(MUL_STEPS - 1))) begin
      mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_a   <= (cmd.mul_sel == MUL_SEL_SX_SQ) ? WIDEW'(sx_mag) : sxx;
      mul_b   <= (cmd.mul_sel == MUL_SEL_SX_SQ) ? MULBW'(sx_mag) : MULBW'(n_reg);
      mul_p   <= '0;
      mul_cnt <= '0;
    end else if (mul_busy) begin
      if (mul_b[0]) begin
        mul_p <= mul_p + mul_a;
      end
      mul_a   <= {mul_a[WIDEW-2:0], 1'b0};
      mul_b   <= {1'b0, mul_b[MULBW-1:1]};
      mul_cnt <= mul_cnt + MCW'(1);
    end
    if (cmd.num_load) begin
      num <= mul_p;
    end else if (cmd.num_sub) begin
      num <= num - mul_p;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [WIDEW-1:0] dv_nq;
  logic [VARW-1:0]  dv_rem, dv_den;
  logic [DCW-1:0]   dv_cnt;
  logic             dv_busy;
  logic [VARW:0]    dv_r2, dv_diff;
  logic             dv_ge;
  logic [2*NW-1:0]  den_g;
  logic [VARW-1:0]  q_sat;

  assign den_g   = (2*NW)'(n_reg) * (2*NW)'(n_reg - NW'(1));
  assign dv_r2   = {dv_rem, dv_nq[WIDEW-1]};
  assign dv_diff = dv_r2 - {1'b0, dv_den};
  assign dv_ge   = dv_r2 >= {1'b0, dv_den};
  assign q_sat   = (|dv_nq[WIDEW-1:VARW]) ? '1 : dv_nq[VARW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy <= 1'b1;
    end else if (dv_busy && (dv_cnt == DCW'(DIV_STEPS - 1))) begin
      dv_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_nq  <= (cmd.div_sel == DIV_SEL_WEIGHT) ? acc : num;
      dv_den <= (cmd.div_sel == DIV_SEL_WEIGHT) ? VARW'(psum) : VARW'(den_g);
      dv_rem <= '0;
      dv_cnt <= '0;
    end else if (dv_busy) begin
      dv_rem <= dv_ge ? dv_diff[VARW-1:0] : dv_r2[VARW-1:0];
      dv_nq  <= {dv_nq[WIDEW-2:0], dv_ge};
      dv_cnt <= dv_cnt + DCW'(1);
    end
  end

  // global and candidate variance
  logic [VARW-1:0] g, v, gv;
  assign gv = sts.n_lt2 ? '0 : q_sat;

  always_ff @(posedge clk) begin
    if (cmd.g_set) begin
      g <= (gv < tiny64) ? fall64 : gv;
    end
    if (cmd.v_set) begin
      v <= sts.psum_zero ? g : q_sat;
    end
  end

  // replacement when too small
  always_comb begin
    v_final   = v;
    src_final = SRC_WEIGHTED;
    if (v < tiny64) begin
      if (f_rdata > tiny64) begin
        v_final   = f_rdata;
        src_final = SRC_FLOOR;
      end else if (g > tiny64) begin
        v_final   = g;
        src_final = SRC_GLOBAL;
      end else begin
        v_final   = fall64;
        src_final = SRC_FALLBACK;
      end
    end
  end
  assign fin_upd = v_final > tiny64;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      component_out <= ctx_comp;
      dimension_out <= ctx_dim;
      variance      <= v_final;
      source        <= src_final;
    end
  end

  // status
  assign sts.is_compute = in_range && (operation == OP_COMPUTE);
  assign sts.loop_done  = !loop_active && !v0 && !v1 && !v2 && !v3;
  assign sts.mul_busy   = mul_busy;
  assign sts.div_busy   = dv_busy;
  assign sts.n_lt2      = n_reg < NW'(2);
  assign sts.psum_zero  = (psum == '0);
  assign sts.out_free   = !res_valid || res_ready;

endmodule

// ===== rtl/core/mwvu_ctrl.sv =====
// Sequencer for one compute request: sample walk, multiply, divide, finish.
// Depends on mwvu_pkg.
module mwvu_ctrl import mwvu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mwvu_sts_t sts,
  output mwvu_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_LOOP  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_GDIV0 = 4'd5;
  localparam logic [3:0] S_GDIV  = 4'd6;
  localparam logic [3:0] S_WCHK  = 4'd7;
  localparam logic [3:0] S_WDIV  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    cmd.take   = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (cmd.take && sts.is_compute) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.start_loop = 1'b1;
        state_next     = S_LOOP;
      end
      S_LOOP: begin
        if (sts.loop_done) begin
          if (sts.n_lt2) begin
            cmd.g_set  = 1'b1;
            state_next = S_WCHK;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_SEL_SXX_N;
            state_next    = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        if (!sts.mul_busy) begin
          cmd.num_load  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_SEL_SX_SQ;
          state_next    = S_MUL2;
        end
      end
      S_MUL2: begin
        if (!sts.mul_busy) begin
          cmd.num_sub = 1'b1;
          state_next  = S_GDIV0;
        end
      end
      S_GDIV0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_GLOBAL;
        state_next    = S_GDIV;
      end
      S_GDIV: begin
        if (!sts.div_busy) begin
          cmd.g_set  = 1'b1;
          state_next = S_WCHK;
        end
      end
      S_WCHK: begin
        if (sts.psum_zero) begin
          cmd.v_set  = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_WEIGHT;
          state_next    = S_WDIV;
        end
      end
      S_WDIV: begin
        if (!sts.div_busy) begin
          cmd.v_set  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && sts.is_compute) |=> (state == S_PREP))
    else $error("compute request did not start the sequence");

  a_walk_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP && !sts.loop_done) |=> (state == S_LOOP))
    else $error("left the sample walk before it drained");

  a_fin_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (!sts.mul_busy && !sts.div_busy))
    else $error("finishing while an arithmetic unit is busy");
`endif

endmodule

// ===== rtl/core/mixture_weighted_variance_update_core.sv =====
// Mixture weighted variance update core: load requests (sample, posterior,
// mean, floor) are taken while the sequencer is idle, and each one in range
// writes one store entry. A compute request walks the first
// min(sample_count, MAX_SAMPLES) = n rows of the named column through a
// four-stage pipeline (one row per cycle, limited by the single read port of
// the sample and posterior memories), then forms the global variance with a
// bit-serial shift-add multiplier (two passes) and a restoring divider (one
// quotient bit per cycle), and the weighted variance with a second divide.
// The global passes are skipped for n below two and the weighted divide when
// the posterior sum is zero. The result waits in an output register; loads
// are accepted while it waits, a compute finishes once the register is free.
// Stores have no reset.
// Depends on mwvu_pkg, mwvu_if, mwvu_ram, mwvu_datapath and mwvu_ctrl.
module mixture_weighted_variance_update_core import mwvu_pkg::*; #(
  parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
  parameter int MAX_DIMS       = DEF_MAX_DIMS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic             clk,
  input  logic             rst,
  mwvu_item_if.sink        items,
  mwvu_result_if.source    results,
  input  logic             cfg_we,
  input  logic [CFGIW-1:0] cfg_index,
  input  logic [CFGW-1:0]  cfg_data
);

  mwvu_cmd_t cmd;
  mwvu_sts_t sts;

  // sequencer: owns request ready and steps the datapath
  mwvu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, sample pipeline, multiplier, divider, result register
  mwvu_datapath #(
    .MAX_SAMPLES    (MAX_SAMPLES),
    .MAX_DIMS       (MAX_DIMS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .operation     (items.operation),
    .sample_index  (items.sample_index),
    .component     (items.component),
    .dimension     (items.dimension),
    .value         (items.value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .component_out (results.component_out),
    .dimension_out (results.dimension_out),
    .variance      (results.variance),
    .source        (results.source_out)
  );

endmodule
